// ===== hw/rtl/sgi_pkg.sv =====
// Shared types and constants for the segment intersection pipeline.
package sgi_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int OUT_W          = 32;

  // Relation codes
  typedef enum logic [1:0] {
    REL_NONE    = 2'd0,
    REL_POINT   = 2'd1,
    REL_OVERLAP = 2'd2
  } rel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] a_start_x;
    logic signed [OUT_W-1:0] a_start_y;
    logic signed [OUT_W-1:0] a_end_x;
    logic signed [OUT_W-1:0] a_end_y;
    logic signed [OUT_W-1:0] b_start_x;
    logic signed [OUT_W-1:0] b_start_y;
    logic signed [OUT_W-1:0] b_end_x;
    logic signed [OUT_W-1:0] b_end_y;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]       relation;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
  } out_item_t;

  // Per-item control traveling alongside the arithmetic
  typedef struct packed {
    logic             general;  // proper crossing, point comes from the divider
    rel_t             relation;
    logic [OUT_W-1:0] pt_x;
    logic [OUT_W-1:0] pt_y;
    logic             neg_x;
    logic             neg_y;
  } sb_t;

endpackage

// ===== hw/rtl/sgi_ifs.sv =====
// Valid/ready channel interfaces for segment pairs and results.
interface sgi_in_if;
  import sgi_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sgi_out_if;
  import sgi_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sgi_front.sv =====
// Front pipeline: side tests, denominator, collinear rules, numerators, divider operands.
module sgi_front #(
  parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  sgi_pkg::in_item_t         up_data,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [3*COORD_BITS+4:0]   dn_num_x,
  output logic [3*COORD_BITS+4:0]   dn_num_y,
  output logic [2*COORD_BITS+3:0]   dn_den,
  output sgi_pkg::sb_t              dn_sb
);
  import sgi_pkg::*;

  localparam int W     = COORD_BITS;
  localparam int DW    = W + 1;      // coordinate differences
  localparam int PW    = 2 * W + 2;  // products of differences
  localparam int SW    = 2 * W + 3;  // side sums, denominator
  localparam int CW    = 2 * W + 1;  // line constants
  localparam int NW    = 3 * W + 2;  // full numerator products
  localparam int N3    = 3 * W + 3;  // numerators
  localparam int NUM_W = 3 * W + 5;
  localparam int DEN_W = 2 * W + 4;
  localparam int NST   = 8;

  // Stage control: a stage loads when empty or when its successor moves
  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = dn_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[NST-1];

  // Point order: a_start x/y, a_end x/y, b_start x/y, b_end x/y
  logic signed [W-1:0]  pt_in [8];
  logic signed [W-1:0]  pt1_r [8];
  logic signed [W-1:0]  pt2_r [8];
  logic signed [DW-1:0] dif1_r [8];
  logic signed [DW-1:0] coef1_r [4];  // a1, b1, a2, b2
  logic signed [DW-1:0] coef2_r [4];
  logic signed [DW-1:0] coef3_r [4];
  logic signed [PW-1:0] sp2_r [8];
  logic signed [PW-1:0] dp2_r [2];
  logic signed [CW-2:0] cp2_r [4];

  // Stage 1: take the low coordinate bits, form line coefficients and offsets
  always_comb begin
    pt_in[0] = up_data.a_start_x[W-1:0];
    pt_in[1] = up_data.a_start_y[W-1:0];
    pt_in[2] = up_data.a_end_x[W-1:0];
    pt_in[3] = up_data.a_end_y[W-1:0];
    pt_in[4] = up_data.b_start_x[W-1:0];
    pt_in[5] = up_data.b_start_y[W-1:0];
    pt_in[6] = up_data.b_end_x[W-1:0];
    pt_in[7] = up_data.b_end_y[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pt1_r      <= pt_in;
      coef1_r[0] <= DW'(pt_in[3]) - DW'(pt_in[1]);
      coef1_r[1] <= DW'(pt_in[0]) - DW'(pt_in[2]);
      coef1_r[2] <= DW'(pt_in[7]) - DW'(pt_in[5]);
      coef1_r[3] <= DW'(pt_in[4]) - DW'(pt_in[6]);
      dif1_r[0]  <= DW'(pt_in[4]) - DW'(pt_in[0]);
      dif1_r[1]  <= DW'(pt_in[5]) - DW'(pt_in[1]);
      dif1_r[2]  <= DW'(pt_in[6]) - DW'(pt_in[0]);
      dif1_r[3]  <= DW'(pt_in[7]) - DW'(pt_in[1]);
      dif1_r[4]  <= DW'(pt_in[0]) - DW'(pt_in[4]);
      dif1_r[5]  <= DW'(pt_in[1]) - DW'(pt_in[5]);
      dif1_r[6]  <= DW'(pt_in[2]) - DW'(pt_in[4]);
      dif1_r[7]  <= DW'(pt_in[3]) - DW'(pt_in[5]);
    end
  end

  // Stage 2: side, denominator and line-constant products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pt2_r   <= pt1_r;
      coef2_r <= coef1_r;
      for (int k = 0; k < 4; k++) begin
        sp2_r[2*k]   <= PW'(coef1_r[(k/2)*2])   * PW'(dif1_r[2*k]);
        sp2_r[2*k+1] <= PW'(coef1_r[(k/2)*2+1]) * PW'(dif1_r[2*k+1]);
      end
      dp2_r[0] <= PW'(coef1_r[0]) * PW'(coef1_r[3]);
      dp2_r[1] <= PW'(coef1_r[2]) * PW'(coef1_r[1]);
      cp2_r[0] <= (CW-1)'(pt1_r[2]) * (CW-1)'(pt1_r[1]);
      cp2_r[1] <= (CW-1)'(pt1_r[0]) * (CW-1)'(pt1_r[3]);
      cp2_r[2] <= (CW-1)'(pt1_r[6]) * (CW-1)'(pt1_r[5]);
      cp2_r[3] <= (CW-1)'(pt1_r[4]) * (CW-1)'(pt1_r[7]);
    end
  end

  // Stage 3: side signs, denominator, line constants and the collinear rules
  logic signed [SW-1:0] sd [4];
  logic [3:0]           sz;
  logic [3:0]           sn;
  logic                 miss;
  logic signed [SW-1:0] den3_nxt;
  logic signed [SW-1:0] den3_r;
  logic signed [CW-1:0] c3_r [2];
  logic signed [W-1:0]  ix, iy, fx, fy, jx, jy, gx, gy, tx, ty;
  rel_t                 col_rel;
  logic [OUT_W-1:0]     col_px, col_py;
  sb_t                  sb3_nxt, sb3_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sd[k] = SW'(sp2_r[2*k]) + SW'(sp2_r[2*k+1]);
      sz[k] = (sd[k] == '0);
      sn[k] = sd[k][SW-1];
    end
    miss = (!sz[0] && !sz[1] && (sn[0] == sn[1])) ||
           (!sz[2] && !sz[3] && (sn[2] == sn[3]));
    den3_nxt = SW'(dp2_r[0]) - SW'(dp2_r[1]);
  end

  // Collinear case: x order, shared endpoints, then x and y range overlap
  always_comb begin
    ix = pt2_r[0]; iy = pt2_r[1]; fx = pt2_r[2]; fy = pt2_r[3];
    jx = pt2_r[4]; jy = pt2_r[5]; gx = pt2_r[6]; gy = pt2_r[7];
    col_rel = REL_NONE;
    col_px  = '0;
    col_py  = '0;
    if (ix > fx) begin
      tx = ix; ty = iy; ix = fx; iy = fy; fx = tx; fy = ty;
    end
    if (jx > gx) begin
      tx = jx; ty = jy; jx = gx; jy = gy; gx = tx; gy = ty;
    end
    tx = '0;
    ty = '0;
    if (ix == gx && iy == gy) begin
      col_rel = REL_POINT;
      col_px  = OUT_W'(ix);
      col_py  = OUT_W'(iy);
    end else if (fx == jx && fy == jy) begin
      col_rel = REL_POINT;
      col_px  = OUT_W'(fx);
      col_py  = OUT_W'(fy);
    end else if (fx < jx || ix > gx) begin
      col_rel = REL_NONE;
    end else begin
      if (iy > fy) begin
        ty = iy; iy = fy; fy = ty;
      end
      if (jy > gy) begin
        ty = jy; jy = gy; gy = ty;
      end
      if (fy < jy || iy > gy) col_rel = REL_NONE;
      else                    col_rel = REL_OVERLAP;
    end
  end

  always_comb begin
    sb3_nxt = '0;
    if (miss) begin
      sb3_nxt.relation = REL_NONE;
    end else if (den3_nxt == '0) begin
      sb3_nxt.relation = col_rel;
      sb3_nxt.pt_x     = col_px;
      sb3_nxt.pt_y     = col_py;
    end else begin
      sb3_nxt.general  = 1'b1;
      sb3_nxt.relation = REL_POINT;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      den3_r  <= den3_nxt;
      c3_r[0] <= CW'(cp2_r[0]) - CW'(cp2_r[1]);
      c3_r[1] <= CW'(cp2_r[2]) - CW'(cp2_r[3]);
      coef3_r <= coef2_r;
      sb3_r   <= sb3_nxt;
    end
  end

  // Stage 4: numerator partial products, line constants split at W bits
  // Terms: b1*c2, b2*c1 (x), a2*c1, a1*c2 (y)
  logic signed [PW-1:0] pph4_r [4];
  logic signed [PW-1:0] ppl4_r [4];
  logic signed [SW-1:0] den4_r;
  sb_t                  sb4_r;
  logic signed [DW-1:0] tcoef [4];
  logic [1:0]           tc [4];

  always_comb begin
    tcoef[0] = coef3_r[1]; tc[0] = 2'd1;
    tcoef[1] = coef3_r[3]; tc[1] = 2'd0;
    tcoef[2] = coef3_r[2]; tc[2] = 2'd0;
    tcoef[3] = coef3_r[0]; tc[3] = 2'd1;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 4; k++) begin
        pph4_r[k] <= PW'(tcoef[k]) * PW'(signed'(c3_r[tc[k][0]][2*W:W]));
        ppl4_r[k] <= PW'(tcoef[k]) * PW'(signed'({1'b0, c3_r[tc[k][0]][W-1:0]}));
      end
      den4_r <= den3_r;
      sb4_r  <= sb3_r;
    end
  end

  // Stage 5: recombine partial products
  logic signed [NW-1:0] t5_r [4];
  logic signed [SW-1:0] den5_r;
  sb_t                  sb5_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 4; k++) begin
        t5_r[k] <= (NW'(pph4_r[k]) <<< W) + NW'(ppl4_r[k]);
      end
      den5_r <= den4_r;
      sb5_r  <= sb4_r;
    end
  end

  // Stage 6: numerators
  logic signed [N3-1:0] nx6_r, ny6_r;
  logic signed [SW-1:0] den6_r;
  sb_t                  sb6_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      nx6_r  <= N3'(t5_r[0]) - N3'(t5_r[1]);
      ny6_r  <= N3'(t5_r[2]) - N3'(t5_r[3]);
      den6_r <= den5_r;
      sb6_r  <= sb5_r;
    end
  end

  // Stage 7: magnitudes and result signs
  logic [N3-1:0] mx7_r, my7_r;
  logic [SW-1:0] md7_r;
  sb_t           sb7_nxt, sb7_r;

  always_comb begin
    sb7_nxt       = sb6_r;
    sb7_nxt.neg_x = (nx6_r != '0) && (nx6_r[N3-1] != den6_r[SW-1]);
    sb7_nxt.neg_y = (ny6_r != '0) && (ny6_r[N3-1] != den6_r[SW-1]);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      mx7_r <= nx6_r[N3-1] ? N3'(-nx6_r) : N3'(nx6_r);
      my7_r <= ny6_r[N3-1] ? N3'(-ny6_r) : N3'(ny6_r);
      md7_r <= den6_r[SW-1] ? SW'(-den6_r) : SW'(den6_r);
      sb7_r <= sb7_nxt;
    end
  end

  // Stage 8: rounding offset, q = floor((2|N| + |D|) / 2|D|)
  logic [NUM_W-1:0] numx8_r, numy8_r;
  logic [DEN_W-1:0] den8_r;
  sb_t              sb8_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      numx8_r <= (NUM_W'(mx7_r) << 1) + NUM_W'(md7_r);
      numy8_r <= (NUM_W'(my7_r) << 1) + NUM_W'(md7_r);
      den8_r  <= DEN_W'(md7_r) << 1;
      sb8_r   <= sb7_r;
    end
  end

  assign dn_num_x = numx8_r;
  assign dn_num_y = numy8_r;
  assign dn_den   = den8_r;
  assign dn_sb    = sb8_r;

  // A crossing handed to the divider never has a zero divisor
  a_gen_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && sb8_r.general |-> den8_r != '0)
    else $error("zero divisor on a crossing item");

endmodule

// ===== hw/rtl/sgi_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for x and y.
module sgi_div #(
  parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [3*COORD_BITS+4:0]   up_num_x,
  input  logic [3*COORD_BITS+4:0]   up_num_y,
  input  logic [2*COORD_BITS+3:0]   up_den,
  input  sgi_pkg::sb_t              up_sb,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [COORD_BITS-1:0]     dn_qx,
  output logic [COORD_BITS-1:0]     dn_qy,
  output sgi_pkg::sb_t              dn_sb
);
  import sgi_pkg::*;

  localparam int W     = COORD_BITS;
  localparam int NUM_W = 3 * W + 5;
  localparam int DEN_W = 2 * W + 4;

  logic [W-1:0] v_r;
  logic [W:0]   en;

  always_comb begin
    en[W] = dn_ready;
    for (int k = W - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < W; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign up_ready = en[0];

  logic [NUM_W-1:0] rx_r [W];
  logic [NUM_W-1:0] ry_r [W];
  logic [W-1:0]     qx_r [W];
  logic [W-1:0]     qy_r [W];
  logic [DEN_W-1:0] d_r  [W];
  sb_t              sb_r [W];

  // Stage k decides quotient bit W-1-k against the divisor shifted into place
  for (genvar k = 0; k < W; k++) begin : g_st
    localparam int SH = W - 1 - k;
    logic [NUM_W-1:0] rx_in, ry_in, dsh;
    logic [W-1:0]     qx_in, qy_in, qx_nxt, qy_nxt;
    logic [DEN_W-1:0] d_in;
    sb_t              sb_in;
    logic             gx, gy;

    if (k == 0) begin : g_first
      assign rx_in = up_num_x;
      assign ry_in = up_num_y;
      assign qx_in = '0;
      assign qy_in = '0;
      assign d_in  = up_den;
      assign sb_in = up_sb;
    end else begin : g_rest
      assign rx_in = rx_r[k-1];
      assign ry_in = ry_r[k-1];
      assign qx_in = qx_r[k-1];
      assign qy_in = qy_r[k-1];
      assign d_in  = d_r[k-1];
      assign sb_in = sb_r[k-1];
    end

    always_comb begin
      dsh        = NUM_W'(d_in) << SH;
      gx         = rx_in >= dsh;
      gy         = ry_in >= dsh;
      qx_nxt     = qx_in;
      qy_nxt     = qy_in;
      qx_nxt[SH] = gx;
      qy_nxt[SH] = gy;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rx_r[k] <= gx ? rx_in - dsh : rx_in;
        ry_r[k] <= gy ? ry_in - dsh : ry_in;
        qx_r[k] <= qx_nxt;
        qy_r[k] <= qy_nxt;
        d_r[k]  <= d_in;
        sb_r[k] <= sb_in;
      end
    end
  end

  assign dn_valid = v_r[W-1];
  assign dn_qx    = qx_r[W-1];
  assign dn_qy    = qy_r[W-1];
  assign dn_sb    = sb_r[W-1];

  // A crossing lies on both segments, so its magnitude never exceeds 2^(W-1)
  a_qx_range: assert property (@(posedge clk) disable iff (!rst_n)
    dn_valid && dn_sb.general && dn_qx[W-1] |-> dn_qx[W-2:0] == '0)
    else $error("x quotient out of coordinate range");

  a_qy_range: assert property (@(posedge clk) disable iff (!rst_n)
    dn_valid && dn_sb.general && dn_qy[W-1] |-> dn_qy[W-2:0] == '0)
    else $error("y quotient out of coordinate range");

endmodule

// ===== hw/rtl/segment_intersection.sv =====
// Top level of the segment intersection unit: front pipeline, divider, output register.
// Takes one pair of segments per transfer and returns one result per pair, in order.
// A new pair is accepted every cycle unless the downstream side stalls the stages. Each
// pair passes the eight front stages (offsets, products, sums, partial products,
// recombination, numerators, magnitudes, rounding offset), the restoring divider
// (one quotient bit per stage) and the output register. Ready follows the downstream
// side through stages, so empty stages keep filling while a result waits at the output.
// Only the low COORD_BITS bits of each coordinate are used, as a signed number.
module segment_intersection #(
  parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sgi_in_if.sink     in_ch,
  sgi_out_if.source  out_ch
);
  import sgi_pkg::*;

  localparam int W     = COORD_BITS;
  localparam int NUM_W = 3 * W + 5;
  localparam int DEN_W = 2 * W + 4;

  logic             f_valid, f_ready;
  logic [NUM_W-1:0] f_num_x, f_num_y;
  logic [DEN_W-1:0] f_den;
  sb_t              f_sb;
  logic             d_valid, d_ready;
  logic [W-1:0]     d_qx, d_qy;
  sb_t              d_sb;

  sgi_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_data  (in_ch.data),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_num_x (f_num_x),
    .dn_num_y (f_num_y),
    .dn_den   (f_den),
    .dn_sb    (f_sb)
  );

  sgi_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_num_x (f_num_x),
    .up_num_y (f_num_y),
    .up_den   (f_den),
    .up_sb    (f_sb),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_qx    (d_qx),
    .dn_qy    (d_qy),
    .dn_sb    (d_sb)
  );

  // Output register: apply signs to the quotients or pass the early result
  logic      out_v_r;
  out_item_t out_r, out_nxt;
  logic      out_en;

  assign out_en  = !out_v_r || out_ch.ready;
  assign d_ready = out_en;

  always_comb begin
    out_nxt.relation = d_sb.relation;
    if (d_sb.general) begin
      out_nxt.point_x = d_sb.neg_x ? -OUT_W'(d_qx) : OUT_W'(d_qx);
      out_nxt.point_y = d_sb.neg_y ? -OUT_W'(d_qy) : OUT_W'(d_qy);
    end else begin
      out_nxt.point_x = d_sb.pt_x;
      out_nxt.point_y = d_sb.pt_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) out_r <= out_nxt;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // Only the three defined relation codes leave the block
  a_rel_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.relation == REL_NONE || out_r.relation == REL_POINT ||
                out_r.relation == REL_OVERLAP)
    else $error("undefined relation code");

  // No point is reported unless the relation is a single point
  a_pt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.relation != REL_POINT |-> out_r.point_x == '0 && out_r.point_y == '0)
    else $error("point reported without a single-point relation");

  // A crossing result always carries the single-point code
  a_gen_rel: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid && d_sb.general |-> d_sb.relation == REL_POINT)
    else $error("crossing item without single-point code");

endmodule
